FILE: src/ring_buffer_double_ended_queue_assert.svh
// assertion macros for the ring buffer deque
`ifndef RING_BUFFER_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define RING_BUFFER_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define RBDQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define RBDQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/rbdq_pkg.sv
// shared types and constants for the ring buffer deque
package rbdq_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int WORD_W    = 32;

   localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
   localparam logic [1:0] REQ_POP_FRONT  = 2'd1;
   localparam logic [1:0] REQ_PUSH_BACK  = 2'd2;
   localparam logic [1:0] REQ_POP_BACK   = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0]               req_type;
      logic signed [WORD_W-1:0] push_value;
   } rbdq_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] pop_value;
      logic [1:0]               status;
      logic                     now_empty;
      logic                     now_full;
   } rbdq_rsp_type;

   // bookkeeping for the request in the read stage, whose ram read may be in flight
   typedef struct packed {
      logic [1:0] status;
      logic       now_empty;
      logic       now_full;
      logic       from_ram;
   } rbdq_stage_type;

endpackage

FILE: src/rbdq_ram.sv
// generic single-write, single-read ram with registered read data
module rbdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ring_buffer_double_ended_queue.sv
// double-ended queue kept in a ring ram, with front and back push and pop
//
//   channel  direction  payload         handshake
//   req      in         rbdq_req_type   req_valid / req_stall
//   rsp      out        rbdq_rsp_type   rsp_valid / rsp_stall
//
// one request per cycle while req_stall is low; a result passes through the ram's
// registered read and then the output register.
// head, tail and the empty flag live in flops and are updated at the transfer
// edge, so the next request already sees them; a push writes the ram at that
// edge and a pop issued right after reads the fresh word.
// reset clears the indices and sets empty; the ram is not cleared.
// a stalled result holds the read stage, and req_stall goes high while that stage holds a request.
`include "ring_buffer_double_ended_queue_assert.svh"

module ring_buffer_double_ended_queue
   import rbdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  rbdq_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rbdq_rsp_type rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   // ring index stepping
   function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? LAST_IDX : idx - 1'b1;
   endfunction

   // pointer state
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic             empty_ff, empty_in;

   // read stage and output register
   logic             s1_valid_ff, s1_valid_in;
   rbdq_stage_type   s1_ff, s1_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rbdq_rsp_type     rsp_data_ff, rsp_data_in;

   // ram ports
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [WORD_W-1:0] rd_data;

   logic req_fire;
   logic advance;
   logic full_now;

   // read stage moves on whenever the output register is free or being drained
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;
   assign full_now  = !empty_ff && (wrap_up(tail_ff) == head_ff);

   rbdq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.push_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // request decode and pointer update
   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      empty_in        = empty_ff;
      wr_en           = 1'b0;
      wr_addr         = head_ff;
      rd_en           = 1'b0;
      rd_addr         = head_ff;
      s1_in.status    = ST_OK;
      s1_in.from_ram  = 1'b0;
      if (req_fire) begin
         case (req_data.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
               if (full_now) begin
                  s1_in.status = ST_OVERFLOW;
               end else if (empty_ff) begin
                  // first entry always lands in slot zero
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b0;
                  wr_en    = 1'b1;
                  wr_addr  = '0;
               end else if (req_data.req_type == REQ_PUSH_FRONT) begin
                  head_in = wrap_down(head_ff);
                  wr_en   = 1'b1;
                  wr_addr = head_in;
               end else begin
                  tail_in = wrap_up(tail_ff);
                  wr_en   = 1'b1;
                  wr_addr = tail_in;
               end
            end
            default: begin
               if (empty_ff) begin
                  s1_in.status = ST_UNDERFLOW;
               end else begin
                  rd_en          = 1'b1;
                  s1_in.from_ram = 1'b1;
                  rd_addr        = (req_data.req_type == REQ_POP_FRONT) ? head_ff : tail_ff;
                  if (head_ff == tail_ff) begin
                     // last entry gone, indices go home
                     empty_in = 1'b1;
                     head_in  = '0;
                     tail_in  = '0;
                  end else if (req_data.req_type == REQ_POP_FRONT) begin
                     head_in = wrap_up(head_ff);
                  end else begin
                     tail_in = wrap_down(tail_ff);
                  end
               end
            end
         endcase
      end
      s1_in.now_empty = empty_in;
      s1_in.now_full  = !empty_in && (wrap_up(tail_in) == head_in);
   end

   // stage valid bits and result assembly
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
         if (s1_valid_ff) begin
            rsp_data_in.status    = s1_ff.status;
            rsp_data_in.now_empty = s1_ff.now_empty;
            rsp_data_in.now_full  = s1_ff.now_full;
            if (s1_ff.from_ram) begin
               rsp_data_in.pop_value = signed'(rd_data);
            end else if (s1_ff.status == ST_UNDERFLOW) begin
               rsp_data_in.pop_value = '1;
            end else begin
               rsp_data_in.pop_value = '0;
            end
         end
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `RBDQ_ASSERT_NOW(a_empty_home, empty_ff, (head_ff == '0) && (tail_ff == '0), "empty deque with stray indices")
   `RBDQ_ASSERT_NOW(a_not_both, rsp_valid, !(rsp_data.now_empty && rsp_data.now_full), "result both empty and full")
   `RBDQ_ASSERT_NEXT(a_pop_reads, req_fire && rd_en, s1_valid_ff && s1_ff.from_ram, "pop lost its ram read")
   `RBDQ_ASSERT_NOW(a_underflow_word, rsp_valid && (rsp_data.status == ST_UNDERFLOW), rsp_data.pop_value == -32'sd1, "underflow without all-ones word")

endmodule
